### rtl/pa_pkg.sv
// ----------------------------------------------------------------------------
// pa_pkg: shared types and constants of the primitive assembler
// Topology codes, register map, face and queue-entry types.
// ----------------------------------------------------------------------------
package pa_pkg;

  localparam int IDX_W = 32;

  // Topology codes held in the mode register
  localparam logic [3:0] MODE_POINTS     = 4'd0;
  localparam logic [3:0] MODE_LINES      = 4'd1;
  localparam logic [3:0] MODE_LINE_STRIP = 4'd2;
  localparam logic [3:0] MODE_LINE_LOOP  = 4'd3;
  localparam logic [3:0] MODE_TRIANGLES  = 4'd4;
  localparam logic [3:0] MODE_TRI_STRIP  = 4'd5;
  localparam logic [3:0] MODE_TRI_FAN    = 4'd6;
  localparam logic [3:0] MODE_QUADS      = 4'd7;
  localparam logic [3:0] MODE_QUAD_STRIP = 4'd8;

  // Face size codes
  localparam logic [1:0] SIZE_POINT = 2'd1;
  localparam logic [1:0] SIZE_LINE  = 2'd2;
  localparam logic [1:0] SIZE_TRI   = 2'd3;

  // Register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_MODE  = 2'd0;
  localparam logic [1:0] REG_BASE  = 2'd1;
  localparam logic [1:0] REG_LIMIT = 2'd2;

  localparam logic [3:0]       MODE_RESET  = MODE_TRIANGLES;
  localparam logic [IDX_W-1:0] BASE_RESET  = '0;
  localparam logic [IDX_W-1:0] LIMIT_RESET = '1;

  // Position in list wraps at twelve
  localparam logic [3:0] POS_LAST = 4'd11;
  localparam logic [1:0] SEEN_MAX = 2'd3;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [3:0]       mode;
    logic [IDX_W-1:0] base;
    logic [IDX_W-1:0] limit;
  } cfg_t;

  typedef struct packed {
    logic [IDX_W-1:0] a;
    logic [IDX_W-1:0] b;
    logic [IDX_W-1:0] c;
  } face_t;

  // Up to two faces caused by one request, both of the same size
  typedef struct packed {
    logic       f0_ok;
    logic       f1_ok;
    logic [1:0] size;
    face_t      f0;
    face_t      f1;
  } entry_t;

endpackage

### rtl/pa_front.sv
// ----------------------------------------------------------------------------
// pa_front: index intake and face classification
// Adds the base vertex, tracks the list history and builds up to two faces.
// ----------------------------------------------------------------------------
module pa_front
  import pa_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [IDX_W-1:0] in_raw_index,
  input  logic             in_end_of_list,
  input  logic             q_full,
  output logic             push,
  output entry_t           push_entry
);

  logic [IDX_W-1:0] first_r, first_nxt;
  logic [IDX_W-1:0] p0_r, p0_nxt, p1_r, p1_nxt, p2_r, p2_nxt;
  logic [3:0]       pos_r, pos_nxt;
  logic [1:0]       seen_r, seen_nxt;

  logic [IDX_W-1:0] idx, first;
  logic             accept;
  logic             want0, want1, cull;
  logic [1:0]       size;
  face_t            f0, f1;

  function automatic logic face_ok(face_t f, logic [1:0] sz, logic do_cull,
                                   logic [IDX_W-1:0] lim);
    logic in_range;
    logic distinct;
    in_range = (f.a < lim) && (sz < SIZE_LINE || f.b < lim) &&
               (sz < SIZE_TRI || f.c < lim);
    distinct = (f.a != f.b) && (f.b != f.c) && (f.a != f.c);
    return in_range && (!do_cull || distinct);
  endfunction

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;
  assign idx      = in_raw_index + cfg.base;
  assign first    = (seen_r == 2'd0) ? idx : first_r;

  always_comb begin
    want0 = 1'b0;
    want1 = 1'b0;
    cull  = 1'b0;
    size  = SIZE_TRI;
    f0    = '0;
    f1    = '0;
    case (cfg.mode)
      MODE_POINTS: begin
        size  = SIZE_POINT;
        want0 = 1'b1;
        f0.a  = idx;
      end
      MODE_LINES: begin
        size  = SIZE_LINE;
        want0 = pos_r[0];
        f0.a  = p0_r;
        f0.b  = idx;
      end
      MODE_LINE_STRIP, MODE_LINE_LOOP: begin
        size  = SIZE_LINE;
        want0 = (seen_r != 2'd0);
        f0.a  = p0_r;
        f0.b  = idx;
        want1 = (cfg.mode == MODE_LINE_LOOP) && in_end_of_list && (seen_r >= 2'd2);
        f1.a  = idx;
        f1.b  = first;
      end
      MODE_TRI_STRIP: begin
        cull  = 1'b1;
        want0 = (seen_r >= 2'd2);
        f0.a  = pos_r[0] ? p0_r : p1_r;
        f0.b  = pos_r[0] ? p1_r : p0_r;
        f0.c  = idx;
      end
      MODE_TRI_FAN: begin
        cull  = 1'b1;
        want0 = (seen_r >= 2'd2);
        f0.a  = first;
        f0.b  = p0_r;
        f0.c  = idx;
      end
      MODE_QUADS: begin
        cull  = 1'b1;
        want0 = (pos_r[1:0] == 2'd3);
        want1 = want0;
        f0    = '{a: p2_r, b: p1_r, c: p0_r};
        f1    = '{a: p2_r, b: p0_r, c: idx};
      end
      MODE_QUAD_STRIP: begin
        cull  = 1'b1;
        want0 = (seen_r == SEEN_MAX) && pos_r[0];
        want1 = want0;
        f0    = '{a: p2_r, b: p1_r, c: idx};
        f1    = '{a: p2_r, b: idx, c: p0_r};
      end
      default: begin
        // plain triangle list: every third index, never culled
        want0 = (pos_r == 4'd2) || (pos_r == 4'd5) || (pos_r == 4'd8) ||
                (pos_r == 4'd11);
        f0    = '{a: p1_r, b: p0_r, c: idx};
      end
    endcase
  end

  always_comb begin
    push_entry.size  = size;
    push_entry.f0    = f0;
    push_entry.f1    = f1;
    push_entry.f0_ok = want0 && face_ok(f0, size, cull, cfg.limit);
    push_entry.f1_ok = want1 && face_ok(f1, size, cull, cfg.limit);
  end

  assign push = accept && (push_entry.f0_ok || push_entry.f1_ok);

  always_comb begin
    first_nxt = first_r;
    p0_nxt    = p0_r;
    p1_nxt    = p1_r;
    p2_nxt    = p2_r;
    pos_nxt   = pos_r;
    seen_nxt  = seen_r;
    if (accept) begin
      if (in_end_of_list) begin
        first_nxt = '0;
        p0_nxt    = '0;
        p1_nxt    = '0;
        p2_nxt    = '0;
        pos_nxt   = '0;
        seen_nxt  = '0;
      end else begin
        first_nxt = first;
        p0_nxt    = idx;
        p1_nxt    = p0_r;
        p2_nxt    = p1_r;
        pos_nxt   = (pos_r >= POS_LAST) ? 4'd0 : pos_r + 4'd1;
        seen_nxt  = (seen_r == SEEN_MAX) ? SEEN_MAX : seen_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r <= '0;
      p0_r    <= '0;
      p1_r    <= '0;
      p2_r    <= '0;
      pos_r   <= '0;
      seen_r  <= '0;
    end else begin
      first_r <= first_nxt;
      p0_r    <= p0_nxt;
      p1_r    <= p1_nxt;
      p2_r    <= p2_nxt;
      pos_r   <= pos_nxt;
      seen_r  <= seen_nxt;
    end
  end

endmodule

### rtl/pa_queue.sv
// ----------------------------------------------------------------------------
// pa_queue: short face queue between intake and output
// Holds classified entries; head is visible without a read cycle.
// ----------------------------------------------------------------------------
module pa_queue
  import pa_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  entry_t push_entry,
  input  logic   pop,
  output entry_t head,
  output logic   empty,
  output logic   full
);

  entry_t            mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign empty = (count_r == '0);
  assign full  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign head  = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

### rtl/pa_back.sv
// ----------------------------------------------------------------------------
// pa_back: face output stage
// Walks the valid faces of the queue head into the output register.
// ----------------------------------------------------------------------------
module pa_back
  import pa_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  entry_t           head,
  input  logic             empty,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [IDX_W-1:0] out_vert_a,
  output logic [IDX_W-1:0] out_vert_b,
  output logic [IDX_W-1:0] out_vert_c,
  output logic [1:0]       out_face_size,
  output logic             out_run_last
);

  logic       sel_r, sel_nxt;
  logic       valid_r, valid_nxt;
  face_t      face_r;
  logic [1:0] size_r;
  logic       last_r;

  logic  load, use_f1, is_last;
  face_t face;

  assign use_f1  = sel_r || !head.f0_ok;
  assign is_last = use_f1 || !head.f1_ok;
  assign face    = use_f1 ? head.f1 : head.f0;
  assign load    = !empty && (!valid_r || !out_stall);
  assign pop     = load && is_last;

  always_comb begin
    sel_nxt   = sel_r;
    valid_nxt = valid_r && out_stall;
    if (load) begin
      valid_nxt = 1'b1;
      sel_nxt   = !is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      face_r <= face;
      size_r <= head.size;
      last_r <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r   <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      sel_r   <= sel_nxt;
      valid_r <= valid_nxt;
    end
  end

  assign out_valid     = valid_r;
  assign out_vert_a    = face_r.a;
  assign out_vert_b    = face_r.b;
  assign out_vert_c    = face_r.c;
  assign out_face_size = size_r;
  assign out_run_last  = last_r;

endmodule

### rtl/primitive_assembler.sv
// ----------------------------------------------------------------------------
// primitive_assembler: vertex index stream to points, lines and triangles
// Offsets each index by the base vertex and assembles faces per topology.
// ----------------------------------------------------------------------------
//   channel  | handshake              | payload
//   ---------+------------------------+--------------------------------------
//   in       | in_valid / in_stall    | in_raw_index, in_end_of_list
//   out      | out_valid / out_stall  | out_vert_a/b/c, out_face_size,
//            |                        | out_run_last
//   config   | psel/penable/pwrite    | paddr, pwdata, prdata, pready
//
// One index request is taken per cycle; intake stalls only when the
// four-entry face queue is full, which takes receiver back pressure: no
// topology averages more than one face per request.
// With no back pressure, a request's first face passes through the queue and then the output register.
// Reset (rst_n, synchronous) clears list history, queue and output valid,
// and loads mode = triangles, base = 0, limit = all ones.
// ----------------------------------------------------------------------------
module primitive_assembler
  import pa_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  // index requests
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [IDX_W-1:0] in_raw_index,
  input  logic             in_end_of_list,
  // face results
  output logic             out_valid,
  input  logic             out_stall,
  output logic [IDX_W-1:0] out_vert_a,
  output logic [IDX_W-1:0] out_vert_b,
  output logic [IDX_W-1:0] out_vert_c,
  output logic [1:0]       out_face_size,
  output logic             out_run_last,
  // register port
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [3:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  cfg_t       cfg_r, cfg_nxt;
  logic [1:0] reg_idx;
  logic       wr_en;

  logic   push, pop, q_empty, q_full;
  entry_t push_entry, head;

  // Register port: word address selects the register, writes complete
  // in the access phase, reads are always ready.
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        REG_MODE:  cfg_nxt.mode  = pwdata[3:0];
        REG_BASE:  cfg_nxt.base  = pwdata;
        REG_LIMIT: cfg_nxt.limit = pwdata;
        default:   cfg_nxt       = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MODE:  prdata = {28'd0, cfg_r.mode};
      REG_BASE:  prdata = cfg_r.base;
      REG_LIMIT: prdata = cfg_r.limit;
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode  <= MODE_RESET;
      cfg_r.base  <= BASE_RESET;
      cfg_r.limit <= LIMIT_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Front: add base, track history, classify and filter faces
  pa_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_raw_index   (in_raw_index),
    .in_end_of_list (in_end_of_list),
    .q_full         (q_full),
    .push           (push),
    .push_entry     (push_entry)
  );

  // Queue: decouple intake from output back pressure
  pa_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .empty      (q_empty),
    .full       (q_full)
  );

  // Back: emit the surviving faces one per cycle while out_stall is low
  pa_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head          (head),
    .empty         (q_empty),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_vert_a    (out_vert_a),
    .out_vert_b    (out_vert_b),
    .out_vert_c    (out_vert_c),
    .out_face_size (out_face_size),
    .out_run_last  (out_run_last)
  );

  // A shown face always carries a real size
  a_size_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_face_size != 2'd0))
    else $error("face without size");

  // Points carry no second or third vertex
  a_point_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_face_size == SIZE_POINT) |-> (out_vert_b == '0 && out_vert_c == '0))
    else $error("point with stray vertices");

  // Lines carry no third vertex
  a_line_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_face_size == SIZE_LINE) |-> (out_vert_c == '0))
    else $error("line with stray third vertex");

  // The queue never takes an entry while full
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !push)
    else $error("queue overflow");

endmodule
